/* src/apq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_pkg: shared types and constants for the array priority queue
// Entry, sweep record, cell control and transaction payload types.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int DEPTH = 8;
  localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int VALW  = 32;
  localparam int PRIW  = 8;
  localparam int OCCW  = 4;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic signed [VALW-1:0] item_value;
    logic [PRIW-1:0]        item_priority;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic signed [VALW-1:0] out_value;
    logic [OCCW-1:0]        occupancy;
  } rsp_t;

  typedef struct packed {
    logic signed [VALW-1:0] value;
    logic [PRIW-1:0]        priority_;
  } entry_t;

  // Running best of the sweep as it travels down the row
  typedef struct packed {
    logic                   hit;
    logic [PRIW-1:0]        priority_;
    logic [IDXW-1:0]        index;
    logic signed [VALW-1:0] value;
  } best_t;

  typedef struct packed {
    logic            write;
    logic            shift;
    logic [CNTW-1:0] count;
    logic [IDXW-1:0] remove_idx;
  } cell_ctl_t;

endpackage

/* src/apq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_cell: one slot of the queue row
// Holds one entry, takes a write or its neighbour's entry on removal, and
// folds itself into the running best as the sweep token passes through.
// ----------------------------------------------------------------------------
module apq_cell
  import apq_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic [IDXW-1:0] idx,
  input  cell_ctl_t       ctl,
  input  entry_t          wr_entry,
  input  entry_t          next_entry,
  output entry_t          entry,
  input  logic            token_in,
  input  best_t           best_in,
  output logic            token_out,
  output best_t           best_out
);

  logic occupied;
  logic take_own;

  assign occupied = CNTW'(idx) < ctl.count;
  // Strict compare keeps the earlier entry on equal priority
  assign take_own = occupied && (!best_in.hit || (entry.priority_ > best_in.priority_));

  always_ff @(posedge clk) begin
    if (ctl.write && (CNTW'(idx) == ctl.count)) begin
      entry <= wr_entry;
    end else if (ctl.shift && (idx >= ctl.remove_idx)) begin
      entry <= next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_out <= 1'b0;
    end else begin
      token_out <= token_in;
    end
  end

  always_ff @(posedge clk) begin
    if (token_in) begin
      if (take_own) begin
        best_out <= '{hit: 1'b1, priority_: entry.priority_, index: idx, value: entry.value};
      end else begin
        best_out <= best_in;
      end
    end
  end

endmodule

/* src/array_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_priority_queue: bounded priority queue on a row of cells
// Enqueue appends at the tail; dequeue sweeps the row for the highest
// priority (earliest on ties) and closes the gap behind it.
// ----------------------------------------------------------------------------
// Enqueue, full and empty: result registered in the cycle after acceptance.
// Dequeue: the sweep token crosses the row one cell per cycle,
//   then a removal step closes the gap and also loads the result register.
// One transaction in flight; the next is taken once the result register is free.
// Reset clears the count, the state and the token row; entries are not cleared.
module array_priority_queue
  import apq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SWEEP = 2'b10
  } state_t;

  state_t          state, state_next;
  logic [CNTW-1:0] count, count_next;
  logic            rsp_valid_next;
  rsp_t            rsp_next;
  logic            accept;
  logic            start;
  logic            load;
  logic            sweep_done;
  cell_ctl_t       ctl;
  entry_t          wr_entry;
  entry_t          entries [DEPTH];
  logic            tokens  [DEPTH];
  best_t           bests   [DEPTH];
  best_t           best_last;
  status_t         status_next;
  logic signed [VALW-1:0] value_next;

  assign req_ready  = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept     = req_valid && req_ready;
  assign sweep_done = (state == S_SWEEP) && tokens[DEPTH-1];
  assign best_last  = bests[DEPTH-1];
  assign wr_entry   = '{value: req.item_value, priority_: req.item_priority};

  always_comb begin
    state_next     = state;
    count_next     = count;
    ctl.write      = 1'b0;
    ctl.shift      = 1'b0;
    ctl.count      = count;
    ctl.remove_idx = best_last.index;
    start          = 1'b0;
    load           = 1'b0;
    status_next    = ST_OK;
    value_next     = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.cmd == CMD_ENQ) begin
            load = 1'b1;
            if (count >= CNTW'(DEPTH)) begin
              status_next = ST_FULL;
            end else begin
              ctl.write  = 1'b1;
              count_next = count + CNTW'(1);
            end
          end else if (count == '0) begin
            load        = 1'b1;
            status_next = ST_EMPTY;
          end else begin
            start      = 1'b1;
            state_next = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        if (sweep_done) begin
          ctl.shift  = 1'b1;
          count_next = count - CNTW'(1);
          load       = 1'b1;
          value_next = best_last.value;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    if (load) begin
      rsp_valid_next = 1'b1;
      rsp_next       = '{status: status_next, out_value: value_next,
                         occupancy: OCCW'(count_next)};
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t next_entry;
      logic   token_in;
      best_t  best_in;
      if (gi == 0) begin : g_head
        assign token_in = start;
        assign best_in  = '0;
      end else begin : g_body
        assign token_in = tokens[gi-1];
        assign best_in  = bests[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign next_entry = '0;
      end else begin : g_inner
        assign next_entry = entries[gi+1];
      end
      apq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .idx        (IDXW'(gi)),
        .ctl        (ctl),
        .wr_entry   (wr_entry),
        .next_entry (next_entry),
        .entry      (entries[gi]),
        .token_in   (token_in),
        .best_in    (best_in),
        .token_out  (tokens[gi]),
        .best_out   (bests[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH))
    else $error("occupancy beyond depth");

  a_no_accept_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !req_ready)
    else $error("transaction accepted during sweep");

  a_deq_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.cmd == CMD_DEQ) && (count != '0)) |=> (state == S_SWEEP))
    else $error("dequeue did not start a sweep");

  a_sweep_found: assert property (@(posedge clk) disable iff (rst)
    sweep_done |-> best_last.hit)
    else $error("sweep ended without a candidate");

  a_sweep_result: assert property (@(posedge clk) disable iff (rst)
    sweep_done |=> (rsp_valid && (rsp.status == ST_OK)))
    else $error("sweep result not presented");

endmodule

/* tb/array_priority_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_priority_queue_tb: self-checking bench for the array priority queue
// Drives enqueue and dequeue transactions through the request channel and
// keeps its own copy of the held entries. Each response is checked against
// that copy: status, dequeued value and occupancy. Random stalls on both
// channels, a long response hold-off and a full drain pause exercise the
// handshakes.
// ----------------------------------------------------------------------------
module array_priority_queue_tb;
  import apq_pkg::*;

  localparam int TIMEOUT_CYCLES = 300000;
  localparam int SETTLE_CYCLES  = DEPTH + 4;
  localparam int PRINT_CAP      = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Shadow of the queue contents, in insertion order
  entry_t held_entry [DEPTH];
  int     held = 0;
  rsp_t   due_rsp [$];

  int error_count  = 0;
  int cycle_count  = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_left    = 0;
  int n_enq        = 0;
  int n_deq        = 0;
  int n_full       = 0;
  int n_empty      = 0;
  int n_checked    = 0;

  array_priority_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, due_rsp.size());
      $display("array_priority_queue verification failed");
      $finish;
    end
  end

  // Apply one operation to the shadow queue and return the response it gives
  function rsp_t serve_queue_op(input req_t op);
    rsp_t res;
    int   top;
    res = '0;
    res.status = ST_OK;
    if (op.cmd == CMD_ENQ) begin
      n_enq++;
      if (held >= DEPTH) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        held_entry[held].value     = op.item_value;
        held_entry[held].priority_ = op.item_priority;
        held++;
      end
    end else begin
      n_deq++;
      if (held == 0) begin
        res.status = ST_EMPTY;
        n_empty++;
      end else begin
        top = 0;
        // strict compare keeps the earliest entry on a tie
        for (int i = 1; i < held; i++)
          if (held_entry[i].priority_ > held_entry[top].priority_) top = i;
        res.out_value = held_entry[top].value;
        for (int i = top; i < held - 1; i++) held_entry[i] = held_entry[i + 1];
        held--;
      end
    end
    res.occupancy = OCCW'(held);
    return res;
  endfunction

  function req_t make_op(input cmd_t c, input logic signed [VALW-1:0] v,
                         input logic [PRIW-1:0] p);
    req_t op;
    op.cmd           = c;
    op.item_value    = v;
    op.item_priority = p;
    return op;
  endfunction

  task report_mismatch(input string what, input logic [63:0] got,
                       input logic [63:0] want);
    if (error_count < PRINT_CAP)
      $display("MISMATCH cycle %0d: %s got 0x%0h want 0x%0h",
               cycle_count, what, got, want);
    error_count++;
  endtask

  // Offer one transaction, idling first at the current sender rate
  task send_op(input req_t op);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= op;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    due_rsp.push_back(serve_queue_op(op));
  endtask

  // Withdraw the request and hold until every response is back
  task drain_responses();
    @(negedge clk);
    req_valid <= 1'b0;
    while (due_rsp.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_responses
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_rsp.size() == 0) begin
        report_mismatch("response with nothing outstanding", 64'(rsp), 64'd0);
      end else begin
        want = due_rsp.pop_front();
        n_checked++;
        if (rsp.status !== want.status)
          report_mismatch("status", 64'(rsp.status), 64'(want.status));
        if (rsp.out_value !== want.out_value)
          report_mismatch("out_value", 64'(rsp.out_value), 64'(want.out_value));
        if (rsp.occupancy !== want.occupancy)
          report_mismatch("occupancy", 64'(rsp.occupancy), 64'(want.occupancy));
      end
    end
  end

  // Empty queue, extreme values and priorities
  task test_empty_and_extremes();
    send_op(make_op(CMD_DEQ, 32'sh1234_5678, 8'hFF));
    send_op(make_op(CMD_ENQ, 32'sh7FFF_FFFF, 8'd0));
    send_op(make_op(CMD_ENQ, 32'sh8000_0000, 8'd255));
    send_op(make_op(CMD_ENQ, -32'sd1, 8'd255));
    send_op(make_op(CMD_ENQ, 32'sd0, 8'd128));
  endtask

  // Fill to the brim, refuse one, then drain in priority and age order
  task test_full_and_ties();
    send_op(make_op(CMD_ENQ, 32'sh0000_0011, 8'd255));
    send_op(make_op(CMD_ENQ, 32'sh5555_5555, 8'd0));
    send_op(make_op(CMD_ENQ, 32'shAAAA_AAAA, 8'd1));
    send_op(make_op(CMD_ENQ, 32'sh0F0F_F0F0, 8'd254));
    send_op(make_op(CMD_ENQ, 32'sh7777_0000, 8'd200));
    repeat (DEPTH + 1) send_op(make_op(CMD_DEQ, 32'sd0, 8'd0));
    send_op(make_op(CMD_DEQ, 32'sd0, 8'd0));
  endtask

  // Hold the response channel for a long stretch while requests keep coming
  task test_receiver_hold();
    drain_responses();
    hold_left = 80;
    repeat (6) send_op(make_op(CMD_ENQ, $urandom, 8'($urandom_range(0, 3))));
    repeat (6) send_op(make_op(CMD_DEQ, $urandom, 8'($urandom)));
  endtask

  // Pause the sender until the queue engine has answered everything
  task test_sender_pause();
    repeat (5) send_op(make_op(CMD_ENQ, $urandom, 8'($urandom)));
    drain_responses();
    repeat (6) send_op(make_op(CMD_DEQ, $urandom, 8'($urandom)));
    drain_responses();
  endtask

  task test_random_traffic(input int n_ops, input int snd_pct, input int rcv_pct);
    int     enq_pct;
    req_t   op;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    enq_pct      = 50;
    for (int n = 0; n < n_ops; n++) begin
      // swing between filling, draining and balanced stretches
      if (n % 24 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 80;
          1: enq_pct = 25;
          default: enq_pct = 50;
        endcase
      end
      op.cmd        = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      op.item_value = $urandom;
      case ($urandom_range(3))
        0, 1: op.item_priority = 8'($urandom_range(0, 3));
        2:    op.item_priority = 8'($urandom);
        default: op.item_priority = $urandom_range(1) ? 8'd255 : 8'd0;
      endcase
      send_op(op);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    snd_idle_pct = 24;
    rcv_idle_pct = 64;
    test_empty_and_extremes();
    test_full_and_ties();
    test_receiver_hold();
    test_sender_pause();
    test_random_traffic(270, 24, 64);
    test_random_traffic(270, 64, 24);
    test_random_traffic(270, 0, 0);

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d responses: %0d enqueues (%0d refused as full),",
             n_checked, n_enq, n_full);
    $display("%0d dequeues (%0d on an empty queue), %0d cycles",
             n_deq, n_empty, cycle_count);
    if (error_count == 0 && due_rsp.size() == 0) begin
      $display("array_priority_queue verification clean");
    end else begin
      $display("array_priority_queue verification failed");
    end
    $finish;
  end

endmodule
